// ----- src/assert_macros.svh -----
//------------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL; ASSERT_OFF compiles them out.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// when ante holds, cons must hold on the same edge
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- src/nplc_pkg.sv -----
//------------------------------------------------------------------------------
// nplc_pkg
// Types and fixed widths for the near plane line clipper.
//------------------------------------------------------------------------------
package nplc_pkg;

	// clip result codes
	typedef enum logic [1:0] {
		SEG_IN      = 2'd0,
		SEG_OUT     = 2'd1,
		SEG_CROSSED = 2'd2
	} clip_status_t;

	// configuration register indexes
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAMERA_X       = 3'd0,
		REG_CAMERA_Y       = 3'd1,
		REG_CAMERA_Z       = 3'd2,
		REG_NORMAL_X       = 3'd3,
		REG_NORMAL_Y       = 3'd4,
		REG_NORMAL_Z       = 3'd5,
		REG_PARALLEL_LIMIT = 3'd6
	} cfg_index_t;

	// datapath widths, fixed by the 32 bit points and 18 bit normal
	localparam int COORD_W = 32;
	localparam int NRM_W   = 18;
	localparam int LIM_W   = 16;
	localparam int DIFF_W  = 34;   // point minus plane point
	localparam int DIR_W   = 33;   // end minus start
	localparam int PROD_W  = 52;   // normal times difference
	localparam int DIST_W  = 54;   // sum of three products
	localparam int MAG_W   = 53;   // magnitude of a distance
	localparam int LO_W    = 27;   // low slice of the numerator multiply
	localparam int HI_W    = MAG_W - LO_W;
	localparam int NUM_W   = MAG_W + COORD_W;
	localparam int DIV_STEPS = COORD_W; // quotient bits, one per stage
	localparam int FRONT_STAGES = 6;
	localparam int BACK_STAGES  = 2;

	// per item data that rides along the divider
	typedef struct packed {
		clip_status_t            status;
		logic                    c1_pos;
		logic [2:0]              neg;
		logic [5:0][COORD_W-1:0] pt;     // 0..2 start, 3..5 end
	} side_t;

endpackage

// ----- src/near_plane_line_clip.sv -----
//------------------------------------------------------------------------------
// near_plane_line_clip
// Clips a 3D segment against the plane through camera + normal facing normal.
//------------------------------------------------------------------------------
// Usage:
//  - input: raise start with the six Q16.16 end point coordinates; a beat is
//    taken on every clock edge where start is high and busy is low. busy is
//    always low: a new segment may enter on every cycle.
//  - output: done pulses for one cycle with clip_status and the clipped
//    points; the receiver must take the beat in that cycle.
//  - pipeline: throughput one segment per cycle. The path runs through six
//    front stages (differences, products, sums, classify, multiply, numerator
//    add), the 32 stage restoring divider (one quotient bit per stage, three
//    lanes) and two back stages (rounding, add and saturate).
//  - config: cfg_wr_en writes cfg_data into register cfg_index at once; write
//    only while no segment is in flight.
//  - reset: arst_n clears all pipeline valid bits and loads the register
//    defaults (camera at origin, normal +z, parallel limit 7).
//------------------------------------------------------------------------------
`include "assert_macros.svh"

module near_plane_line_clip
	import nplc_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  start,
	output logic                  busy,
	input  logic signed [31:0]    start_x,
	input  logic signed [31:0]    start_y,
	input  logic signed [31:0]    start_z,
	input  logic signed [31:0]    end_x,
	input  logic signed [31:0]    end_y,
	input  logic signed [31:0]    end_z,
	output logic                  done,
	output logic [1:0]            clip_status,
	output logic signed [31:0]    out_start_x,
	output logic signed [31:0]    out_start_y,
	output logic signed [31:0]    out_start_z,
	output logic signed [31:0]    out_end_x,
	output logic signed [31:0]    out_end_y,
	output logic signed [31:0]    out_end_z
);

	localparam int LATENCY = FRONT_STAGES + DIV_STEPS + BACK_STAGES;

	// configuration registers
	logic signed [COORD_W-1:0] cam_q [3];
	logic signed [NRM_W-1:0]   nrm_q [3];
	logic [LIM_W-1:0]          limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_q[0] <= '0;
			cam_q[1] <= '0;
			cam_q[2] <= '0;
			nrm_q[0] <= '0;
			nrm_q[1] <= '0;
			nrm_q[2] <= NRM_W'(1 << FRAC_BITS);
			limit_q  <= LIM_W'(7);
		end else if (cfg_wr_en) begin
			case (cfg_index_t'(cfg_index))
				REG_CAMERA_X:       cam_q[0] <= cfg_data[COORD_W-1:0];
				REG_CAMERA_Y:       cam_q[1] <= cfg_data[COORD_W-1:0];
				REG_CAMERA_Z:       cam_q[2] <= cfg_data[COORD_W-1:0];
				REG_NORMAL_X:       nrm_q[0] <= cfg_data[NRM_W-1:0];
				REG_NORMAL_Y:       nrm_q[1] <= cfg_data[NRM_W-1:0];
				REG_NORMAL_Z:       nrm_q[2] <= cfg_data[NRM_W-1:0];
				REG_PARALLEL_LIMIT: limit_q  <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// fully pipelined, never holds a beat off
	assign busy = 1'b0;

	logic [5:0][COORD_W-1:0] pt_in;
	assign pt_in = {end_z, end_y, end_x, start_z, start_y, start_x};

	// valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_f1, done_q;
	logic [DIV_STEPS:0] v_sd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_sd   <= '0;
			v_f1   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start & ~busy;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			v_sd   <= {v_sd[DIV_STEPS-1:0], v_s5};
			v_f1   <= v_sd[DIV_STEPS];
			done_q <= v_f1;
		end
	end

	// s1: differences to the plane point and direction
	logic signed [DIFF_W-1:0] sp_s1 [3], ep_s1 [3];
	logic signed [DIR_W-1:0]  dir_s1 [3];
	logic [5:0][COORD_W-1:0]  pt_s1;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			sp_s1[k]  <= DIFF_W'($signed(pt_in[k]))
				- (DIFF_W'(cam_q[k]) + DIFF_W'(nrm_q[k]));
			ep_s1[k]  <= DIFF_W'($signed(pt_in[3+k]))
				- (DIFF_W'(cam_q[k]) + DIFF_W'(nrm_q[k]));
			dir_s1[k] <= DIR_W'($signed(pt_in[3+k])) - DIR_W'($signed(pt_in[k]));
		end
		pt_s1 <= pt_in;
	end

	// s2: products with the normal
	logic signed [PROD_W-1:0] pc1_s2 [3], pc2_s2 [3], pd_s2 [3];
	logic signed [DIR_W-1:0]  dir_s2 [3];
	logic [5:0][COORD_W-1:0]  pt_s2;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			pc1_s2[k] <= nrm_q[k] * sp_s1[k];
			pc2_s2[k] <= nrm_q[k] * ep_s1[k];
			pd_s2[k]  <= nrm_q[k] * dir_s1[k];
			dir_s2[k] <= dir_s1[k];
		end
		pt_s2 <= pt_s1;
	end

	// s3: signed distances and direction term
	logic signed [DIST_W-1:0] c1_s3, c2_s3, d_s3;
	logic signed [DIR_W-1:0]  dir_s3 [3];
	logic [5:0][COORD_W-1:0]  pt_s3;

	always_ff @(posedge clk) begin
		c1_s3  <= DIST_W'(pc1_s2[0]) + DIST_W'(pc1_s2[1]) + DIST_W'(pc1_s2[2]);
		c2_s3  <= DIST_W'(pc2_s2[0]) + DIST_W'(pc2_s2[1]) + DIST_W'(pc2_s2[2]);
		d_s3   <= DIST_W'(pd_s2[0]) + DIST_W'(pd_s2[1]) + DIST_W'(pd_s2[2]);
		dir_s3 <= dir_s2;
		pt_s3  <= pt_s2;
	end

	// s4: classify, take magnitudes and offset signs
	logic [MAG_W-1:0]   c1_abs, d_abs;
	logic [COORD_W-1:0] dir_abs [3];
	logic [MAG_W-1:0]   thr;
	logic               c1_gt, c1_lt, c2_gt, c2_lt;
	clip_status_t       status_nx;

	always_comb begin
		c1_lt = c1_s3[DIST_W-1];
		c2_lt = c2_s3[DIST_W-1];
		c1_gt = !c1_lt && (c1_s3 != '0);
		c2_gt = !c2_lt && (c2_s3 != '0);
		c1_abs = c1_lt ? MAG_W'(-c1_s3) : MAG_W'(c1_s3);
		d_abs  = d_s3[DIST_W-1] ? MAG_W'(-d_s3) : MAG_W'(d_s3);
		for (int k = 0; k < 3; k++) begin
			dir_abs[k] = dir_s3[k][DIR_W-1] ? COORD_W'(-dir_s3[k]) : COORD_W'(dir_s3[k]);
		end
		thr = {{(MAG_W-LIM_W){1'b0}}, limit_q} << FRAC_BITS;
		if (c1_gt && c2_gt) begin
			status_nx = SEG_IN;
		end else if (c1_lt && c2_lt) begin
			status_nx = SEG_OUT;
		end else if (d_abs < thr) begin
			status_nx = SEG_OUT;
		end else begin
			status_nx = SEG_CROSSED;
		end
	end

	logic [MAG_W-1:0]   magc_s4, magd_s4;
	logic [COORD_W-1:0] magdir_s4 [3];
	side_t              side_s4;

	always_ff @(posedge clk) begin
		magc_s4 <= c1_abs;
		magd_s4 <= d_abs;
		for (int k = 0; k < 3; k++) begin
			magdir_s4[k]   <= dir_abs[k];
			side_s4.neg[k] <= c1_gt ^ dir_s3[k][DIR_W-1] ^ d_s3[DIST_W-1];
		end
		side_s4.status <= status_nx;
		side_s4.c1_pos <= c1_gt;
		side_s4.pt     <= pt_s3;
	end

	// s5: numerator partial products |c1| * |dir|
	logic [LO_W+COORD_W-1:0] pplo_s5 [3];
	logic [HI_W+COORD_W-1:0] pphi_s5 [3];
	logic [MAG_W-1:0]        magd_s5;
	side_t                   side_s5;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			pplo_s5[k] <= magc_s4[LO_W-1:0] * magdir_s4[k];
			pphi_s5[k] <= magc_s4[MAG_W-1:LO_W] * magdir_s4[k];
		end
		magd_s5 <= magd_s4;
		side_s5 <= side_s4;
	end

	// divider stage registers, index 0 is the numerator stage (s6)
	logic [MAG_W-1:0]   rem_sd  [0:DIV_STEPS][3];
	logic [COORD_W-1:0] qx_sd   [0:DIV_STEPS][3];
	logic [MAG_W-1:0]   magd_sd [0:DIV_STEPS];
	side_t              side_sd [0:DIV_STEPS];
	logic [NUM_W-1:0]   num [3];

	// s6: full numerator, top bits seed the remainder
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			num[k] = {pphi_s5[k], {LO_W{1'b0}}} + NUM_W'(pplo_s5[k]);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			rem_sd[0][k] <= num[k][NUM_W-1:COORD_W];
			qx_sd[0][k]  <= num[k][COORD_W-1:0];
		end
		magd_sd[0] <= magd_s5;
		side_sd[0] <= side_s5;
	end

	// restoring divider: one quotient bit per stage, dividend bits shift out
	// of qx while quotient bits shift in
	for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_div
		logic [MAG_W:0]     trial [3];
		logic [MAG_W:0]     diff  [3];
		logic [MAG_W-1:0]   rem_nx [3];
		logic [COORD_W-1:0] qx_nx  [3];

		always_comb begin
			for (int k = 0; k < 3; k++) begin
				trial[k] = {rem_sd[i-1][k], qx_sd[i-1][k][COORD_W-1]};
				diff[k]  = trial[k] - {1'b0, magd_sd[i-1]};
				if (trial[k] >= {1'b0, magd_sd[i-1]}) begin
					rem_nx[k] = diff[k][MAG_W-1:0];
					qx_nx[k]  = {qx_sd[i-1][k][COORD_W-2:0], 1'b1};
				end else begin
					rem_nx[k] = trial[k][MAG_W-1:0];
					qx_nx[k]  = {qx_sd[i-1][k][COORD_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			rem_sd[i]  <= rem_nx;
			qx_sd[i]   <= qx_nx;
			magd_sd[i] <= magd_sd[i-1];
			side_sd[i] <= side_sd[i-1];
		end
	end

	// f1: round half away from zero and apply sign; the rounded quotient never
	// exceeds |dir|, so it fits 32 bits; a zero divisor wraps it to zero
	logic [COORD_W-1:0]      qr [3];
	logic signed [DIR_W-1:0] off_f1 [3];
	side_t                   side_f1;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			qr[k] = qx_sd[DIV_STEPS][k]
				+ COORD_W'({rem_sd[DIV_STEPS][k], 1'b0} >= {1'b0, magd_sd[DIV_STEPS]});
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			off_f1[k] <= side_sd[DIV_STEPS].neg[k] ? -DIR_W'(qr[k]) : DIR_W'(qr[k]);
		end
		side_f1 <= side_sd[DIV_STEPS];
	end

	// f2: intersection point, saturate, replace the end behind the plane
	logic signed [DIFF_W-1:0] isum [3];
	logic [COORD_W-1:0]       isat [3];
	logic [5:0][COORD_W-1:0]  res_nx;

	always_comb begin
		res_nx = side_f1.pt;
		for (int k = 0; k < 3; k++) begin
			isum[k] = DIFF_W'($signed(side_f1.pt[k])) + DIFF_W'(off_f1[k]);
			if (isum[k] > DIFF_W'(32'sh7fff_ffff)) begin
				isat[k] = 32'h7fff_ffff;
			end else if (isum[k] < -DIFF_W'(35'sh8000_0000)) begin
				isat[k] = 32'h8000_0000;
			end else begin
				isat[k] = isum[k][COORD_W-1:0];
			end
			if (side_f1.status == SEG_CROSSED) begin
				if (side_f1.c1_pos) begin
					res_nx[3+k] = isat[k];
				end else begin
					res_nx[k] = isat[k];
				end
			end
		end
	end

	logic [5:0][COORD_W-1:0] res_q;
	clip_status_t            status_q;

	always_ff @(posedge clk) begin
		res_q    <= res_nx;
		status_q <= side_f1.status;
	end

	// result ports
	assign done        = done_q;
	assign clip_status = status_q;
	assign out_start_x = res_q[0];
	assign out_start_y = res_q[1];
	assign out_start_z = res_q[2];
	assign out_end_x   = res_q[3];
	assign out_end_y   = res_q[4];
	assign out_end_z   = res_q[5];

	// checks
	`ASSERT_CLK(a_latency, clk, arst_n, start |-> ##LATENCY done, "beat lost in pipeline")
	`ASSERT_IMPL(a_start_pass, clk, arst_n, done && clip_status != SEG_CROSSED, out_start_x == $past(start_x, LATENCY), "start point altered")
	`ASSERT_IMPL(a_end_pass, clk, arst_n, done && clip_status != SEG_CROSSED, out_end_z == $past(end_z, LATENCY), "end point altered")

endmodule
